/* hdl/bsf_pkg.sv */
// shared types and constants of the binaural stereo fir block
`timescale 1ns / 1ps

package bsf_pkg;

    // sample and coefficient, tap index, gain, step and length widths
    localparam int SMP_W    = 16;
    localparam int TAP_IN_W = 5;
    localparam int GAIN_W   = 25;
    localparam int STEP_W   = 21;
    localparam int LEN_W    = 16;

    // gain ramp start (0.9 in Q24, rounded down) and ceiling
    localparam logic [GAIN_W-1:0] GAIN_START = 25'd15099494;
    localparam logic [GAIN_W-1:0] GAIN_MAX   = 25'd33554431;

    // register reset values
    localparam logic             XF_EN_RST   = 1'b1;
    localparam logic [LEN_W-1:0] XF_LEN_RST  = 16'd960;
    localparam logic [STEP_W-1:0] STEP_RST   = 21'd1748;

    // item kinds carried in tuser
    typedef enum logic [1:0] {
        FN_AUDIO = 2'd0,
        FN_TAP   = 2'd1,
        FN_POS   = 2'd2,
        FN_NONE  = 2'd3
    } t_func;

    // register word index
    typedef enum logic [1:0] {
        REG_XF_EN   = 2'd0,
        REG_XF_LEN  = 2'd1,
        REG_STEP    = 2'd2
    } t_reg;

    // sequencer states
    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_MAC   = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_FIN   = 5'b10000
    } t_state;

    // accumulator control
    typedef struct packed {
        logic clr;
        logic en;
    } t_mac_ctl;

    // handoff to the output scaling pipeline
    typedef struct packed {
        logic              vld;
        logic              scale;
        logic [GAIN_W-1:0] gain;
    } t_fin;

endpackage

/* hdl/bsf_mac.sv */
// dual multiply-accumulate over the delay line and both coefficient sets
`timescale 1ns / 1ps

module bsf_mac
    import bsf_pkg::*;
#(
    parameter int ACC_W = 37
) (
    input  logic                    i_clk,
    input  t_mac_ctl                i_ctl,
    input  logic signed [SMP_W-1:0] i_smp,
    input  logic signed [SMP_W-1:0] i_coef_l,
    input  logic signed [SMP_W-1:0] i_coef_r,
    output logic signed [ACC_W-1:0] o_acc_l,
    output logic signed [ACC_W-1:0] o_acc_r
);

    logic signed [2*SMP_W-1:0] w_prod_l;
    logic signed [2*SMP_W-1:0] w_prod_r;
    logic signed [ACC_W-1:0]   r_acc_l;
    logic signed [ACC_W-1:0]   r_acc_r;

    // one tap product per side
    assign w_prod_l = i_smp * i_coef_l;
    assign w_prod_r = i_smp * i_coef_r;

    // accumulate, cleared at the start of each sample
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_acc_l <= '0;
            r_acc_r <= '0;
        end else if (i_ctl.en) begin
            r_acc_l <= r_acc_l + ACC_W'(w_prod_l);
            r_acc_r <= r_acc_r + ACC_W'(w_prod_r);
        end
    end

    assign o_acc_l = r_acc_l;
    assign o_acc_r = r_acc_r;

endmodule

/* hdl/bsf_out.sv */
// gain scaling, truncation toward zero and int16 saturation for one side
`timescale 1ns / 1ps

module bsf_out
    import bsf_pkg::*;
#(
    parameter int ACC_W = 37
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_fin                    i_fin,
    input  logic signed [ACC_W-1:0] i_acc,
    output logic                    o_vld,
    output logic [SMP_W-1:0]        o_smp
);

    localparam int PROD_W = 32 + GAIN_W;
    localparam int VAL_W  = ACC_W - 15;

    logic [ACC_W-1:0]  w_mag;
    logic [31:0]       w_mag_clip;
    logic [VAL_W-1:0]  w_val;

    logic              r_v1;
    logic              r_neg1;
    logic              r_scale1;
    logic [GAIN_W-1:0] r_gain1;
    logic [ACC_W-1:0]  r_mag1;

    logic              r_v2;
    logic              r_neg2;
    logic              r_scale2;
    logic [PROD_W-1:0] r_prod2;
    logic [VAL_W-1:0]  r_sh2;

    logic              r_vld;
    logic [SMP_W-1:0]  r_smp;

    // magnitude of the sum
    assign w_mag = i_acc[ACC_W-1] ? ACC_W'(-i_acc) : ACC_W'(i_acc);

    // stage 1: sign and magnitude
    always_ff @(posedge i_clk) begin
        r_neg1   <= i_acc[ACC_W-1];
        r_scale1 <= i_fin.scale;
        r_gain1  <= i_fin.gain;
        r_mag1   <= w_mag;
    end

    // a scaled gain is at least 0.9, so anything past 32 bits saturates anyway
    assign w_mag_clip = (|r_mag1[ACC_W-1:32]) ? 32'hFFFF_FFFF : r_mag1[31:0];

    // stage 2: gain product or plain Q15 shift
    always_ff @(posedge i_clk) begin
        r_neg2   <= r_neg1;
        r_scale2 <= r_scale1;
        r_prod2  <= PROD_W'(w_mag_clip) * PROD_W'(r_gain1);
        r_sh2    <= r_mag1[ACC_W-1:15];
    end

    assign w_val = r_scale2 ? VAL_W'(r_prod2[PROD_W-1:39]) : r_sh2;

    // stage 3: saturate and restore sign
    always_ff @(posedge i_clk) begin
        if (r_neg2) begin
            r_smp <= (w_val >= VAL_W'(32768)) ? 16'h8000 : 16'(-w_val[SMP_W-1:0]);
        end else begin
            r_smp <= (w_val >= VAL_W'(32767)) ? 16'h7FFF : w_val[SMP_W-1:0];
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_vld <= 1'b0;
        end else begin
            r_v1  <= i_fin.vld;
            r_v2  <= r_v1;
            r_vld <= r_v2;
        end
    end

    assign o_vld = r_vld;
    assign o_smp = r_smp;

endmodule

/* hdl/binaural_stereo_fir_crossfade.sv */
// top level: sequencer, delay and coefficient memories, ramp state, ports
//
//  channel   | signals             | carries
//  ----------+---------------------+------------------------------------------
//  input     | s_axis_t*           | audio sample, tap pair write, position change
//  output    | m_axis_t*           | left and right ear samples
//  config    | psel/penable/...    | crossfade_enable, crossfade_length, fade_step
//
// an audio sample holds the input off after its transfer while the single read
// port of each memory sweeps one tap per cycle, and through the drain and launch
// states that follow; the result then passes the scaling pipelines into the
// output register. tap writes and position changes leave the sequencer idle.
// after reset a clearing pass over every address zeroes both memories before
// the first transfer is taken. a result waiting at the output does not block
// new input; it delays the launch of the next result, which keeps the input waiting.
`timescale 1ns / 1ps

module binaural_stereo_fir_crossfade
    import bsf_pkg::*;
#(
    parameter int TAPS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // audio_in[15:0], tap_index[20:16], coef_left_in[36:21], coef_right_in[52:37]
    input  logic [55:0] s_axis_tdata,
    // func[1:0]
    input  logic [1:0]  s_axis_tuser,
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // left_smp[15:0], right_smp[31:16]
    output logic [31:0] m_axis_tdata,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW    = $clog2(TAPS);
    localparam int ACC_W = 2 * SMP_W + $clog2(TAPS);
    localparam logic [AW-1:0] LAST = AW'(TAPS - 1);

    // memories
    logic [SMP_W-1:0]   r_dly_mem  [TAPS];
    logic [2*SMP_W-1:0] r_coef_mem [TAPS];
    logic [SMP_W-1:0]   r_dly_rd;
    logic [2*SMP_W-1:0] r_coef_rd;

    // sequencer
    t_state            r_state, n_state;
    logic [AW-1:0]     r_clr_addr;
    logic [AW-1:0]     r_wp, n_wp;
    logic [AW-1:0]     r_rp;
    logic [AW-1:0]     r_j;
    logic              r_rd_vld;
    logic              r_out_pend;

    // registers and ramp state
    logic              r_xf_en;
    logic [LEN_W-1:0]  r_xf_len;
    logic [STEP_W-1:0] r_step;
    logic              r_fading, n_fading;
    logic [LEN_W-1:0]  r_count, n_count;
    logic [GAIN_W-1:0] r_gain, n_gain;
    logic              r_scale, n_scale;
    logic [GAIN_W-1:0] r_gain_use;
    logic [GAIN_W:0]   w_gain_sum;

    // output register
    logic              r_m_valid;
    logic [31:0]       r_m_data;

    // input fields
    t_func             w_func;
    logic [SMP_W-1:0]  w_audio;
    logic [31:0]       w_tap;
    logic              w_tap_ok;
    logic              w_s_xfer;
    logic              w_m_xfer;
    logic              w_cfg_wr;
    logic              w_launch;

    t_mac_ctl          w_mac_ctl;
    t_fin              w_fin;
    logic signed [ACC_W-1:0] w_acc_l;
    logic signed [ACC_W-1:0] w_acc_r;
    logic              w_vld_l;
    logic              w_vld_r;
    logic [SMP_W-1:0]  w_smp_l;
    logic [SMP_W-1:0]  w_smp_r;

    assign w_func   = t_func'(s_axis_tuser);
    assign w_audio  = s_axis_tdata[15:0];
    assign w_tap    = 32'(s_axis_tdata[20:16]);
    assign w_tap_ok = w_tap < TAPS;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_s_xfer      = s_axis_tvalid && s_axis_tready;
    assign w_m_xfer      = r_m_valid && m_axis_tready;
    assign w_launch      = (r_state == ST_FIN) && !r_out_pend;

    // register port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xf_en  <= XF_EN_RST;
            r_xf_len <= XF_LEN_RST;
            r_step   <= STEP_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_XF_EN:  r_xf_en  <= pwdata[0];
                REG_XF_LEN: r_xf_len <= pwdata[LEN_W-1:0];
                REG_STEP:   r_step   <= pwdata[STEP_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_XF_EN:  prdata = 32'(r_xf_en);
            REG_XF_LEN: prdata = 32'(r_xf_len);
            REG_STEP:   prdata = 32'(r_step);
            default:    prdata = '0;
        endcase
    end

    // ramp decision and position change
    assign w_gain_sum = {1'b0, r_gain} + (GAIN_W + 1)'(r_step);

    always_comb begin
        n_fading = r_fading;
        n_count  = r_count;
        n_gain   = r_gain;
        n_scale  = r_scale;
        n_wp     = r_wp;
        if (w_s_xfer) begin
            unique case (w_func)
                FN_AUDIO: begin
                    n_wp    = (r_wp == '0) ? LAST : r_wp - 1'b1;
                    n_scale = 1'b0;
                    if (r_fading) begin
                        if (r_count >= r_xf_len) begin
                            n_fading = 1'b0;
                        end else begin
                            n_scale = 1'b1;
                            n_count = r_count + 1'b1;
                            n_gain  = (w_gain_sum > (GAIN_W + 1)'(GAIN_MAX))
                                      ? GAIN_MAX : w_gain_sum[GAIN_W-1:0];
                        end
                    end
                end
                FN_POS: begin
                    if (r_xf_en) begin
                        n_fading = 1'b1;
                        n_count  = '0;
                        n_gain   = GAIN_START;
                    end
                end
                default: ;
            endcase
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr_addr == LAST) n_state = ST_IDLE;
            ST_IDLE:  if (w_s_xfer && w_func == FN_AUDIO) n_state = ST_MAC;
            ST_MAC:   if (r_j == LAST) n_state = ST_DRAIN;
            ST_DRAIN: n_state = ST_FIN;
            ST_FIN:   if (!r_out_pend) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_wp       <= '0;
            r_rp       <= '0;
            r_j        <= '0;
            r_rd_vld   <= 1'b0;
            r_out_pend <= 1'b0;
            r_fading   <= 1'b0;
            r_count    <= '0;
            r_gain     <= '0;
            r_scale    <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wp     <= n_wp;
            r_fading <= n_fading;
            r_count  <= n_count;
            r_gain   <= n_gain;
            r_scale  <= n_scale;
            r_rd_vld <= (r_state == ST_MAC);
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            // tap sweep
            if (w_s_xfer && w_func == FN_AUDIO) begin
                r_rp <= n_wp;
                r_j  <= '0;
            end else if (r_state == ST_MAC) begin
                r_rp <= (r_rp == LAST) ? '0 : r_rp + 1'b1;
                r_j  <= r_j + 1'b1;
            end
            // one result in flight until its output transfer
            if (w_launch) begin
                r_out_pend <= 1'b1;
            end else if (w_m_xfer) begin
                r_out_pend <= 1'b0;
            end
            if (w_vld_l) begin
                r_m_valid <= 1'b1;
            end else if (w_m_xfer) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // gain used by the current sample
    always_ff @(posedge i_clk) begin
        if (w_s_xfer && w_func == FN_AUDIO) begin
            r_gain_use <= r_gain;
        end
    end

    // delay line memory: clearing pass, then newest sample at the write pointer
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CLEAR) begin
            r_dly_mem[r_clr_addr] <= '0;
        end else if (w_s_xfer && w_func == FN_AUDIO) begin
            r_dly_mem[n_wp] <= w_audio;
        end
        r_dly_rd <= r_dly_mem[r_rp];
    end

    // coefficient memory: {right, left} per tap
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CLEAR) begin
            r_coef_mem[r_clr_addr] <= '0;
        end else if (w_s_xfer && w_func == FN_TAP && w_tap_ok) begin
            r_coef_mem[w_tap[AW-1:0]] <= s_axis_tdata[52:21];
        end
        r_coef_rd <= r_coef_mem[r_j];
    end

    // accumulators
    assign w_mac_ctl.clr = w_s_xfer && (w_func == FN_AUDIO);
    assign w_mac_ctl.en  = r_rd_vld;

    bsf_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .i_clk    (i_clk),
        .i_ctl    (w_mac_ctl),
        .i_smp    (r_dly_rd),
        .i_coef_l (r_coef_rd[SMP_W-1:0]),
        .i_coef_r (r_coef_rd[2*SMP_W-1:SMP_W]),
        .o_acc_l  (w_acc_l),
        .o_acc_r  (w_acc_r)
    );

    // output scaling, one pipeline per side
    assign w_fin.vld   = w_launch;
    assign w_fin.scale = r_scale;
    assign w_fin.gain  = r_gain_use;

    bsf_out #(
        .ACC_W (ACC_W)
    ) u_out_l (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fin   (w_fin),
        .i_acc   (w_acc_l),
        .o_vld   (w_vld_l),
        .o_smp   (w_smp_l)
    );

    bsf_out #(
        .ACC_W (ACC_W)
    ) u_out_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fin   (w_fin),
        .i_acc   (w_acc_r),
        .o_vld   (w_vld_r),
        .o_smp   (w_smp_r)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (w_vld_l && w_vld_r) begin
            r_m_data <= {w_smp_r, w_smp_l};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

/* dv/bsf_ear_checker.sv */
// checker for the binaural fir block: tracks filter state, predicts ear samples, compares
`timescale 1ns / 1ps

module bsf_ear_checker
    import bsf_pkg::*;
#(
    parameter int TAPS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    // audio_in[15:0], tap_index[20:16], coef_left_in[36:21], coef_right_in[52:37]
    input  logic [55:0] s_axis_tdata,
    // func[1:0]
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // left_smp[15:0], right_smp[31:16]
    input  logic [31:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [SMP_W-1:0] left;
        logic [SMP_W-1:0] right;
    } t_ears;

    // shadow of the block state
    logic signed [SMP_W-1:0] delay_mem [TAPS];
    logic signed [SMP_W-1:0] coef_l    [TAPS];
    logic signed [SMP_W-1:0] coef_r    [TAPS];
    logic                    ramp_on;
    logic [LEN_W-1:0]        ramp_cnt;
    logic [GAIN_W-1:0]       ramp_gain;

    // shadow of the registers
    logic                    xf_en;
    logic [LEN_W-1:0]        xf_len;
    logic [STEP_W-1:0]       xf_step;

    // ear samples still owed by the block, oldest first
    t_ears ears_due [$];

    // truncate toward zero, then saturate to 16 bits
    function automatic logic [SMP_W-1:0] ear_sample(input longint acc, input bit scale,
                                                    input logic [GAIN_W-1:0] gain);
        bit              neg;
        longint unsigned mag;
        neg = (acc < 0);
        mag = neg ? -acc : acc;
        if (scale)
            mag = (mag * 64'(gain)) >> 39;
        else
            mag = mag >> 15;
        if (neg)
            return (mag >= 64'd32768) ? 16'h8000 : 16'(64'd0 - mag);
        return (mag >= 64'd32767) ? 16'h7FFF : 16'(mag);
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        if (o_fail_count < REPORT_MAX)
            $display("%0t mismatch on %s: expected %h actual %h", $realtime, what, exp_v, act_v);
        o_fail_count++;
    endtask

    // apply one input transfer to the shadow state, queue the ear pair it causes
    task automatic step_filter(input t_func fn, input logic [55:0] d);
        logic [TAP_IN_W-1:0] tap;
        longint              acc_l;
        longint              acc_r;
        bit                  scale;
        logic [GAIN_W-1:0]   gain;
        logic [GAIN_W:0]     next_gain;
        t_ears               ears;
        tap = d[20:16];
        case (fn)
            FN_TAP: begin
                if (int'(tap) < TAPS) begin
                    coef_l[tap] = d[36:21];
                    coef_r[tap] = d[52:37];
                end
            end
            FN_POS: begin
                if (xf_en) begin
                    ramp_on   = 1'b1;
                    ramp_cnt  = '0;
                    ramp_gain = GAIN_START;
                end
            end
            FN_AUDIO: begin
                for (int j = TAPS - 1; j > 0; j--)
                    delay_mem[j] = delay_mem[j-1];
                delay_mem[0] = d[15:0];
                acc_l = 0;
                acc_r = 0;
                for (int j = 0; j < TAPS; j++) begin
                    acc_l += longint'(delay_mem[j]) * longint'(coef_l[j]);
                    acc_r += longint'(delay_mem[j]) * longint'(coef_r[j]);
                end
                // gain ramp: scale while the count is below the length
                scale = 1'b0;
                gain  = '0;
                if (ramp_on) begin
                    if (ramp_cnt >= xf_len) begin
                        ramp_on = 1'b0;
                    end else begin
                        scale     = 1'b1;
                        gain      = ramp_gain;
                        ramp_cnt  = ramp_cnt + 1'b1;
                        next_gain = {1'b0, ramp_gain} + xf_step;
                        ramp_gain = (next_gain > GAIN_MAX) ? GAIN_MAX : next_gain[GAIN_W-1:0];
                    end
                end
                ears.left  = ear_sample(acc_l, scale, gain);
                ears.right = ear_sample(acc_r, scale, gain);
                ears_due.push_back(ears);
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_ears       want;
        logic [31:0] rd_exp;
        bit          rd_known;
        if (!i_rst_n) begin
            for (int j = 0; j < TAPS; j++) begin
                delay_mem[j] = '0;
                coef_l[j]    = '0;
                coef_r[j]    = '0;
            end
            ramp_on      = 1'b0;
            ramp_cnt     = '0;
            ramp_gain    = '0;
            xf_en        = XF_EN_RST;
            xf_len       = XF_LEN_RST;
            xf_step      = STEP_RST;
            ears_due.delete();
            o_fail_count = 0;
        end else begin
            // output transfer against the oldest expectation
            if (m_axis_tvalid && m_axis_tready) begin
                if (ears_due.size() == 0) begin
                    note_mismatch("unexpected result", 32'd0, m_axis_tdata);
                end else begin
                    want = ears_due.pop_front();
                    if (m_axis_tdata[15:0] !== want.left)
                        note_mismatch("left_smp", 32'(want.left), 32'(m_axis_tdata[15:0]));
                    if (m_axis_tdata[31:16] !== want.right)
                        note_mismatch("right_smp", 32'(want.right), 32'(m_axis_tdata[31:16]));
                end
            end
            // input transfer
            if (s_axis_tvalid && s_axis_tready)
                step_filter(t_func'(s_axis_tuser), s_axis_tdata);
            // register port: follow writes, check reads
            if (psel && penable && pready) begin
                rd_known = 1'b1;
                rd_exp   = '0;
                case (paddr[3:2])
                    REG_XF_EN: begin
                        if (pwrite) xf_en = pwdata[0];
                        rd_exp = 32'(xf_en);
                    end
                    REG_XF_LEN: begin
                        if (pwrite) xf_len = pwdata[LEN_W-1:0];
                        rd_exp = 32'(xf_len);
                    end
                    REG_STEP: begin
                        if (pwrite) xf_step = pwdata[STEP_W-1:0];
                        rd_exp = 32'(xf_step);
                    end
                    default: rd_known = 1'b0;
                endcase
                if (!pwrite && rd_known && prdata !== rd_exp)
                    note_mismatch("register read", rd_exp, prdata);
            end
        end
        o_pending = ears_due.size();
    end

endmodule

/* dv/testbench.sv */
// testbench top: clock, reset, stimulus and register writes for the binaural fir block
`timescale 1ns / 1ps

module testbench;
    import bsf_pkg::*;

    localparam int TAPS            = 32;
    localparam int CLK_PERIOD      = 8;
    localparam int DRAIN_CYCLES    = TAPS + 8;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int HOLD_AFTER      = 250;
    localparam int HOLD_CYCLES     = 600;

    localparam logic [SMP_W-1:0]  SMP_MAX  = 16'h7FFF;
    localparam logic [SMP_W-1:0]  SMP_MIN  = 16'h8000;
    localparam logic [LEN_W-1:0]  LEN_MAX  = 16'hFFFF;
    localparam logic [STEP_W-1:0] STEP_MAX = 21'd1677722;
    // register index past the end of the map
    localparam logic [1:0]        REG_SPARE = 2'd3;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // audio_in[15:0], tap_index[20:16], coef_left_in[36:21], coef_right_in[52:37]
    logic [55:0] s_axis_tdata  = '0;
    // func[1:0]
    logic [1:0]  s_axis_tuser  = FN_AUDIO;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // left_smp[15:0], right_smp[31:16]
    logic [31:0] m_axis_tdata;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [3:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int burst_left   = 0;
    int results_seen = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    binaural_stereo_fir_crossfade #(
        .TAPS(TAPS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    bsf_ear_checker #(
        .TAPS(TAPS)
    ) checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // one register transfer: setup and access phases, then the bus goes idle
    task automatic apb_xfer(input bit wr, input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic en, input logic [LEN_W-1:0] len,
                              input logic [STEP_W-1:0] step);
        apb_xfer(1'b1, REG_XF_EN, 32'(en));
        apb_xfer(1'b1, REG_XF_LEN, 32'(len));
        apb_xfer(1'b1, REG_STEP, 32'(step));
        apb_xfer(1'b0, REG_XF_EN, '0);
        apb_xfer(1'b0, REG_XF_LEN, '0);
        apb_xfer(1'b0, REG_STEP, '0);
    endtask

    // offer one item; bursts of random length with random gaps between them
    task automatic send_item(input t_func fn, input logic [15:0] smp, input logic [4:0] tap,
                             input logic [15:0] cl, input logic [15:0] cr);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(0, 4);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= {3'b000, cr, cl, tap, smp};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        burst_left--;
    endtask

    task automatic send_audio(input logic [15:0] smp);
        send_item(FN_AUDIO, smp, 5'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic send_tap(input logic [4:0] tap, input logic [15:0] cl, input logic [15:0] cr);
        send_item(FN_TAP, 16'($urandom), tap, cl, cr);
    endtask

    task automatic send_ctl(input t_func fn);
        send_item(fn, 16'($urandom), 5'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // stop offering, wait for every owed result, then let the sequencer drain
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // samples and coefficients: extremes, small values and full range
    function automatic logic [15:0] rnd_value();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       return SMP_MAX;
            1:       return SMP_MIN;
            2:       return '0;
            3, 4, 5: return 16'($urandom_range(0, 4095) - 2048);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_item(input int pos_pct, output int counted);
        int pick;
        pick    = $urandom_range(0, 99);
        counted = 1;
        if (pick < pos_pct) begin
            send_ctl(FN_POS);
        end else if (pick < pos_pct + 14) begin
            send_tap(5'($urandom), rnd_value(), rnd_value());
        end else if (pick < pos_pct + 19) begin
            send_ctl(FN_NONE);
            counted = 0;
        end else begin
            send_audio(rnd_value());
        end
    endtask

    // count output transfers for the receiver
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            results_seen <= results_seen + 1;
    end

    // receiver: stall patterns that change now and then, plus one long hold-off
    initial begin : receiver
        int  mode;
        int  mode_left;
        int  cyc;
        bit  held;
        mode      = 0;
        mode_left = 0;
        cyc       = 0;
        held      = 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (!held && results_seen >= HOLD_AFTER) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 200);
            end
            mode_left--;
            case (mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= (cyc % 5 == 0);
            endcase
        end
    end

    // stimulus and verdict
    initial begin : stimulus
        int counted;
        int n;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default registers: extremes of samples and coefficients, ramp start and restart
        send_audio(SMP_MAX);
        send_tap(5'd0, SMP_MAX, SMP_MIN);
        send_tap(5'd31, SMP_MIN, SMP_MAX);
        send_tap(5'd1, SMP_MIN, SMP_MIN);
        send_audio(SMP_MIN);
        send_audio(SMP_MAX);
        send_audio('0);
        send_ctl(FN_NONE);
        send_ctl(FN_POS);
        send_audio(SMP_MAX);
        send_audio(SMP_MIN);
        send_ctl(FN_POS);
        send_audio(16'd12345);
        settle();

        // zero length ramp ends on the next sample; write past the register map
        set_config(1'b1, '0, STEP_MAX);
        apb_xfer(1'b1, REG_SPARE, 32'hFFFF_FFFF);
        apb_xfer(1'b0, REG_SPARE, '0);
        send_ctl(FN_POS);
        send_audio(16'hFFFF);
        send_audio(16'h0001);
        settle();

        // a running ramp carries on after crossfade is disabled
        set_config(1'b1, 16'd3, '0);
        send_ctl(FN_POS);
        send_audio(16'd100);
        settle();
        set_config(1'b0, 16'd3, '0);
        send_ctl(FN_POS);
        repeat (4) send_audio(rnd_value());

        // random phases, each under its own register setting
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph)
                0: set_config(1'b1, LEN_MAX, STEP_MAX);
                1: set_config(1'b1, '0, '0);
                2: set_config(1'b0, 16'($urandom), 21'($urandom_range(0, STEP_MAX)));
                3: set_config(1'b1, 16'($urandom_range(1, 12)), 21'($urandom_range(0, STEP_MAX)));
                4: set_config(XF_EN_RST, XF_LEN_RST, STEP_RST);
                5: set_config(1'b1, 16'($urandom_range(1, 40)), STEP_MAX);
                6: set_config(1'b1, LEN_MAX, 21'($urandom_range(0, STEP_MAX)));
                default: set_config(1'($urandom), 16'($urandom), 21'($urandom_range(0, STEP_MAX)));
            endcase
            n = 0;
            while (n < ITEMS_PER_PHASE) begin
                random_item((ph == 0) ? 2 : 10, counted);
                n += counted;
            end
        end
        settle();

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // run limit
    initial begin : watchdog
        #10ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

/* sim.f */
hdl/bsf_pkg.sv
hdl/bsf_mac.sv
hdl/bsf_out.sv
hdl/binaural_stereo_fir_crossfade.sv
dv/bsf_ear_checker.sv
dv/testbench.sv
